[hw/rtl/sfr_pkg.sv]
package sfr_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_PATTERN_DEF     = 16;
  localparam int MAX_REPLACEMENT_DEF = 16;

  // Fixed field widths
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_W = 5;

  localparam logic [7:0] NEWLINE = 8'd10;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LO,
    REG_PAT_HI,
    REG_PAT_LEN,
    REG_REP_LO,
    REG_REP_HI,
    REG_REP_LEN
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_TAIL,
    ST_REPL,
    ST_DONE
  } state_t;

  // Sequencer to output stage: one byte produced, or end of the item's run
  typedef struct packed {
    logic       push;
    logic       finish;
    logic [7:0] data;
  } emit_t;

endpackage

[hw/rtl/sfr_match.sv]
module sfr_match #(
  parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF,
  localparam int CntW = $clog2(MAX_PATTERN + 1)
) (
  input  logic [7:0]      win [MAX_PATTERN],
  input  logic [7:0]      pat [MAX_PATTERN],
  input  logic [CntW-1:0] cnt,
  output logic            hit
);
  import sfr_pkg::*;

  // Window compare: the first cnt held bytes against the pattern head
  always_comb begin
    hit = 1'b1;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if ((j < int'(cnt)) && (win[j] != pat[j])) hit = 1'b0;
    end
  end

endmodule

[hw/rtl/sfr_out.sv]
module sfr_out (
  input  logic            clk,
  input  logic            rst_n,
  input  sfr_pkg::emit_t  em,
  output logic            adv,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last_of_run
);
  import sfr_pkg::*;

  logic       pv_r, pv_nxt;
  logic [7:0] pb_r;
  logic       ov_r, ov_nxt;
  logic [7:0] ob_r;
  logic       ol_r;
  logic       slot_free;
  logic       move;

  // One byte is kept back so the last one of a run can be flagged
  assign slot_free = !ov_r || out_ready;
  assign adv       = !pv_r || slot_free;
  assign move      = pv_r && adv && (em.push || em.finish);

  always_comb begin
    pv_nxt = pv_r;
    if (adv && em.push) pv_nxt = 1'b1;
    else if (move) pv_nxt = 1'b0;
  end

  always_comb begin
    ov_nxt = ov_r;
    if (move) ov_nxt = 1'b1;
    else if (out_ready) ov_nxt = 1'b0;
  end

  // Control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      pv_r <= pv_nxt;
      ov_r <= ov_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (adv && em.push) pb_r <= em.data;
    if (move) begin
      ob_r <= pb_r;
      ol_r <= !em.push;
    end
  end

  assign out_valid       = ov_r;
  assign out_byte        = ob_r;
  assign out_last_of_run = ol_r;

endmodule

[hw/rtl/sfr_ctrl.sv]
module sfr_ctrl #(
  parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_byte,
  input  logic                       in_end_of_input,
  input  logic [7:0]                 pat [MAX_PATTERN],
  input  logic [sfr_pkg::LEN_W-1:0]  pat_len,
  input  logic [7:0]                 rep [MAX_REPLACEMENT],
  input  logic [sfr_pkg::LEN_W-1:0]  rep_len,
  input  logic                       pat_clear,
  input  logic                       adv,
  output sfr_pkg::emit_t             em
);
  import sfr_pkg::*;

  localparam int CntW  = $clog2(MAX_PATTERN + 1);
  localparam int IdxW  = $clog2(MAX_PATTERN);
  localparam int RiW   = $clog2(MAX_REPLACEMENT + 1);
  localparam int RIdxW = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1;

  state_t          state_r, state_nxt;
  logic [7:0]      hold_r [MAX_PATTERN];
  logic [7:0]      hold_nxt [MAX_PATTERN];
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            tail_en_r, tail_en_nxt;
  logic [7:0]      tail_byte_r, tail_byte_nxt;
  logic [RiW-1:0]  ri_r, ri_nxt;
  logic            line_open_r, line_open_nxt;
  logic            hit;
  logic            full;
  logic            held_ge_len;
  logic            is_nl;

  sfr_match #(.MAX_PATTERN(MAX_PATTERN)) u_match (
    .win (hold_r),
    .pat (pat),
    .cnt (cnt_r),
    .hit (hit)
  );

  assign full        = (LEN_W'(cnt_r) == pat_len);
  assign held_ge_len = (LEN_W'(cnt_r) >= pat_len);
  assign is_nl       = (in_byte == NEWLINE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_end_of_input || is_nl || held_ge_len) state_nxt = ST_FLUSH;
          else state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit && full) state_nxt = ST_REPL;
        else if (hit) state_nxt = ST_DONE;
      end
      ST_FLUSH: begin
        if (cnt_r == '0) state_nxt = ST_TAIL;
      end
      ST_TAIL: begin
        if (!tail_en_r || adv) state_nxt = ST_DONE;
      end
      ST_REPL: begin
        if (LEN_W'(ri_r) == rep_len) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (adv) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    in_ready      = 1'b0;
    em            = '0;
    hold_nxt      = hold_r;
    cnt_nxt       = cnt_r;
    tail_en_nxt   = tail_en_r;
    tail_byte_nxt = tail_byte_r;
    ri_nxt        = ri_r;
    line_open_nxt = line_open_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          tail_byte_nxt = NEWLINE;
          if (in_end_of_input) begin
            tail_en_nxt   = line_open_r;
            line_open_nxt = 1'b0;
          end else if (is_nl) begin
            tail_en_nxt   = 1'b1;
            line_open_nxt = 1'b0;
          end else begin
            line_open_nxt = 1'b1;
            if (held_ge_len) begin
              tail_en_nxt   = 1'b1;
              tail_byte_nxt = in_byte;
            end else begin
              hold_nxt[cnt_r[IdxW-1:0]] = in_byte;
              cnt_nxt = cnt_r + 1'b1;
            end
          end
        end
      end
      ST_SCAN: begin
        if (hit && full) begin
          cnt_nxt = '0;
          ri_nxt  = '0;
        end else if (!hit && adv) begin
          // release the oldest byte, try the next start position
          em.push = 1'b1;
          em.data = hold_r[0];
          for (int j = 0; j < MAX_PATTERN - 1; j++) hold_nxt[j] = hold_r[j+1];
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_FLUSH: begin
        if ((cnt_r != '0) && adv) begin
          em.push = 1'b1;
          em.data = hold_r[0];
          for (int j = 0; j < MAX_PATTERN - 1; j++) hold_nxt[j] = hold_r[j+1];
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_TAIL: begin
        if (tail_en_r && adv) begin
          em.push = 1'b1;
          em.data = tail_byte_r;
        end
      end
      ST_REPL: begin
        if ((LEN_W'(ri_r) != rep_len) && adv) begin
          em.push = 1'b1;
          em.data = rep[ri_r[RIdxW-1:0]];
          ri_nxt  = ri_r + 1'b1;
        end
      end
      ST_DONE: begin
        em.finish = 1'b1;
      end
      default: ;
    endcase
    // pattern rewrite restarts the matcher
    if (pat_clear) cnt_nxt = '0;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      line_open_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      line_open_r <= line_open_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    hold_r      <= hold_nxt;
    tail_en_r   <= tail_en_nxt;
    tail_byte_r <= tail_byte_nxt;
    ri_r        <= ri_nxt;
  end

endmodule

[hw/rtl/stream_find_replace_top.sv]
// Channel   Handshake             Payload
// in        in_valid/in_ready     in_byte, in_end_of_input
// out       out_valid/out_ready   out_byte, out_last_of_run
// cfg       cfg_we                cfg_index, cfg_data (write only)
//
// Steps per item. Held byte: accept, window compare with the oldest byte released at
// each failed start, close of run. Full match: accept, window compare, replacement
// bytes, close of run. Newline, end of input or pass-through byte: accept, held bytes,
// tail byte if any, close of run. One comparator; one output byte per cycle unless the
// output stalls. Reset is synchronous, active low, and clears the held bytes and open
// line. A stalled output holds the sequencer once its look-ahead byte is full.
module stream_find_replace_top #(
  parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_byte,
  input  logic                           in_end_of_input,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_byte,
  output logic                           out_last_of_run,
  input  logic                           cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sfr_pkg::*;

  localparam logic [LEN_W-1:0] MaxPat = LEN_W'(MAX_PATTERN);
  localparam logic [LEN_W-1:0] MaxRep = LEN_W'(MAX_REPLACEMENT);

  logic [7:0]       pat_r [MAX_PATTERN];
  logic [7:0]       rep_r [MAX_REPLACEMENT];
  logic [LEN_W-1:0] pat_len_r;
  logic [LEN_W-1:0] rep_len_r;
  logic [LEN_W-1:0] pat_len;
  logic [LEN_W-1:0] rep_len;
  logic             pat_clear;
  logic             adv;
  emit_t            em;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < MAX_PATTERN; j++) pat_r[j] <= '0;
      for (int j = 0; j < MAX_REPLACEMENT; j++) rep_r[j] <= '0;
      pat_len_r <= '0;
      rep_len_r <= '0;
    end else if (cfg_we) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        if ((cfg_index == REG_PAT_LO && j < 8) || (cfg_index == REG_PAT_HI && j >= 8))
          pat_r[j] <= cfg_data[(j % 8) * 8 +: 8];
      end
      for (int j = 0; j < MAX_REPLACEMENT; j++) begin
        if ((cfg_index == REG_REP_LO && j < 8) || (cfg_index == REG_REP_HI && j >= 8))
          rep_r[j] <= cfg_data[(j % 8) * 8 +: 8];
      end
      if (cfg_index == REG_PAT_LEN) pat_len_r <= cfg_data[LEN_W-1:0];
      if (cfg_index == REG_REP_LEN) rep_len_r <= cfg_data[LEN_W-1:0];
    end
  end

  assign pat_clear = cfg_we && (cfg_index == REG_PAT_LO || cfg_index == REG_PAT_HI ||
                                cfg_index == REG_PAT_LEN);

  // Lengths above the built-in limits act as the limit
  assign pat_len = (pat_len_r > MaxPat) ? MaxPat : pat_len_r;
  assign rep_len = (rep_len_r > MaxRep) ? MaxRep : rep_len_r;

  sfr_ctrl #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .pat             (pat_r),
    .pat_len         (pat_len),
    .rep             (rep_r),
    .rep_len         (rep_len),
    .pat_clear       (pat_clear),
    .adv             (adv),
    .em              (em)
  );

  sfr_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .em              (em),
    .adv             (adv),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule
